// ----- sv/pns_pkg.sv -----
// Shared types and constants for the polygon normalize, scale and rotate block.
`timescale 1ns / 1ps
`default_nettype none
package pns_pkg;

	localparam int COORD_W   = 16;                // input coordinate and box width
	localparam int SIZE_W    = 12;                // target size and scaled coordinate
	localparam int PROD_W    = COORD_W + SIZE_W;  // scaled product before division
	localparam int TRIG_W    = 16;                // sine and cosine registers
	localparam int WORD_W    = 32;                // stored coordinate word
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_COS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_SIN  = 3'd3;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SC_RD,
		ST_SC_MUL,
		ST_SC_DIVGO,
		ST_SC_DIV,
		ST_SC_ROT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} vertex_word_t;

endpackage
`default_nettype wire

// ----- sv/pns_vertex_ram.sv -----
// Vertex store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pns_vertex_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [ADDR_W-1:0]         waddr,
	input  wire pns_pkg::vertex_word_t wdata,
	input  wire [ADDR_W-1:0]         raddr,
	output pns_pkg::vertex_word_t    rdata
);

	pns_pkg::vertex_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/pns_divider.sv -----
// Restoring divider producing one quotient bit per cycle for the scale step.
`timescale 1ns / 1ps
`default_nettype none
module pns_divider (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [pns_pkg::PROD_W-1:0]     dividend,
	input  wire [pns_pkg::COORD_W-1:0]    divisor,
	output logic [pns_pkg::SIZE_W-1:0]    quotient,
	output logic                          done
);

	localparam int STEP_W = $clog2(pns_pkg::SIZE_W);

	logic [pns_pkg::PROD_W-1:0] rem_q;
	logic [pns_pkg::PROD_W-1:0] dsr_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       ge;

	// The quotient is known to fit SIZE_W bits because the dividend never
	// reaches divisor times two to the SIZE_W.
	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(pns_pkg::SIZE_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= dividend;
			dsr_q    <= pns_pkg::PROD_W'({divisor, {(pns_pkg::SIZE_W - 1){1'b0}}});
			quotient <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quotient <= {quotient[pns_pkg::SIZE_W-2:0], ge};
			dsr_q    <= dsr_q >> 1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/pns_rotate.sv -----
// Quarter turns plus residual rotation in two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module pns_rotate #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_vld,
	input  wire [pns_pkg::SIZE_W-1:0]           sx,
	input  wire [pns_pkg::SIZE_W-1:0]           sy,
	input  wire [1:0]                           turns,
	input  wire signed [pns_pkg::TRIG_W-1:0]    cos_v,
	input  wire signed [pns_pkg::TRIG_W-1:0]    sin_v,
	output logic                                out_vld,
	output logic signed [pns_pkg::WORD_W-1:0]   rx,
	output logic signed [pns_pkg::WORD_W-1:0]   ry
);

	localparam int TW    = pns_pkg::SIZE_W + 1;
	localparam int MUL_W = TW + pns_pkg::TRIG_W;
	localparam int SUM_W = MUL_W + 1;
	localparam int BIAS  = (1 << TRIG_FRAC_BITS) - 1;

	logic signed [TW-1:0]    px, py, tx, ty;
	logic signed [MUL_W-1:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic                    vld_s1;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [SUM_W:0]   adj_x, adj_y;

	assign px = $signed({1'b0, sx});
	assign py = $signed({1'b0, sy});

	// Each quarter turn maps (x, y) to (-y, x).
	always_comb begin
		case (turns)
			2'd1: begin tx = -py; ty = px;  end
			2'd2: begin tx = -px; ty = -py; end
			2'd3: begin tx = py;  ty = -px; end
			default: begin tx = px; ty = py; end
		endcase
	end

	always_ff @(posedge clk) begin
		pxc_s1 <= tx * cos_v;
		pys_s1 <= ty * sin_v;
		pxs_s1 <= tx * sin_v;
		pyc_s1 <= ty * cos_v;
	end

	assign sum_x = SUM_W'(pxc_s1) - SUM_W'(pys_s1);
	assign sum_y = SUM_W'(pxs_s1) + SUM_W'(pyc_s1);

	// Adding the bias to negative sums makes the arithmetic shift truncate
	// toward zero.
	assign adj_x = (SUM_W + 1)'(sum_x) + (sum_x < 0 ? (SUM_W + 1)'(BIAS) : '0);
	assign adj_y = (SUM_W + 1)'(sum_y) + (sum_y < 0 ? (SUM_W + 1)'(BIAS) : '0);

	always_ff @(posedge clk) begin
		rx <= pns_pkg::WORD_W'(adj_x >>> TRIG_FRAC_BITS);
		ry <= pns_pkg::WORD_W'(adj_y >>> TRIG_FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/polygon_normalize_scale_rotate.sv -----
// Polygon normalize, scale and rotate: collects vertices, transforms, emits them.
//
// Vertices enter on the input channel (in_valid/in_ready), one transfer per
// cycle while the block is loading. final_vertex marks the last one; vertices
// beyond MAX_POINTS are dropped and reported through overflowed. The bounding
// box is tracked while loading.
// After the final vertex the block makes one pass over the vertex store that
// shifts, scales, turns and rotates each vertex and writes it back; the scale
// step divides with a 12-step divider. A second pass reads each vertex and
// shifts it to the origin again, then presents it on the output channel
// (out_valid/out_ready) and reads the next vertex only after it transfers.
// While the receiver stalls the result is held in the output register and
// the block waits; no input is taken until the last vertex has transferred.
// The configuration port is written by cfg_write, cfg_index and cfg_data and
// should only be written while the block is loading with no vertex stored.
// Reset clears count, flags, state and configuration; the store needs no clear.
`timescale 1ns / 1ps
`default_nettype none
module polygon_normalize_scale_rotate #(
	parameter int MAX_POINTS     = 64,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_write,
	input  wire [pns_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [pns_pkg::TRIG_W-1:0]        cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire signed [pns_pkg::COORD_W-1:0] vertex_x,
	input  wire signed [pns_pkg::COORD_W-1:0] vertex_y,
	input  wire                              final_vertex,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [pns_pkg::COORD_W-1:0]      out_x,
	output logic [pns_pkg::COORD_W-1:0]      out_y,
	output logic                             out_last,
	output logic                             degenerate,
	output logic                             overflowed
);

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CW     = pns_pkg::COORD_W;
	localparam int WW     = pns_pkg::WORD_W;

	pns_pkg::state_t state_q, state_d;

	logic [pns_pkg::SIZE_W-1:0]        target_q;
	logic [1:0]                        turns_q;
	logic signed [pns_pkg::TRIG_W-1:0] cos_q, sin_q;

	logic [CNT_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]    idx_q;
	logic                 ovf_q;
	logic signed [CW-1:0] minx_q, miny_q, maxx_q, maxy_q;
	logic signed [WW-1:0] rminx_q, rminy_q;
	logic [pns_pkg::PROD_W-1:0] prodx_q, prody_q;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	pns_pkg::vertex_word_t ram_wdata, ram_rdata;

	logic [CW-1:0]  wid, hgt, big;
	logic           degen;
	logic           in_xfer, store_ok, last_idx;
	logic           div_start, div_done, div_done_y;
	logic [pns_pkg::SIZE_W-1:0] qx, qy, sx, sy;
	logic           rot_in, rot_out;
	logic signed [WW-1:0] rx, ry;
	logic [CW-1:0]  dx, dy;
	logic [WW-1:0]  ex, ey;

	assign wid   = CW'(maxx_q - minx_q);
	assign hgt   = CW'(maxy_q - miny_q);
	assign big   = (wid > hgt) ? wid : hgt;
	assign degen = (big == '0);

	assign in_ready = (state_q == pns_pkg::ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign store_ok = (cnt_q < CNT_W'(MAX_POINTS));
	assign last_idx = (CNT_W'(idx_q) == cnt_q - 1'b1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= pns_pkg::SIZE_W'(256);
			turns_q  <= 2'd0;
			cos_q    <= pns_pkg::TRIG_W'(16384);
			sin_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				pns_pkg::REG_TARGET_SIZE:   target_q <= cfg_data[pns_pkg::SIZE_W-1:0];
				pns_pkg::REG_QUARTER_TURNS: turns_q  <= cfg_data[1:0];
				pns_pkg::REG_RESIDUAL_COS:  cos_q    <= $signed(cfg_data);
				pns_pkg::REG_RESIDUAL_SIN:  sin_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Memory port selection: loading writes new vertices, the transform pass
	// writes each rotated vertex back to the entry it was read from.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata.x = WW'(rx);
		ram_wdata.y = WW'(ry);
		if (state_q == pns_pkg::ST_LOAD) begin
			ram_we      = in_xfer && store_ok;
			ram_waddr   = cnt_q[ADDR_W-1:0];
			ram_wdata.x = WW'(vertex_x);
			ram_wdata.y = WW'(vertex_y);
		end else if (state_q == pns_pkg::ST_SC_ROT) begin
			ram_we = rot_out;
		end
	end

	pns_vertex_ram #(
		.DEPTH  (MAX_POINTS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign dx = ram_rdata.x[CW-1:0] - minx_q;
	assign dy = ram_rdata.y[CW-1:0] - miny_q;

	assign div_start = (state_q == pns_pkg::ST_SC_DIVGO);

	pns_divider u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prodx_q),
		.divisor  (big),
		.quotient (qx),
		.done     (div_done)
	);

	pns_divider u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prody_q),
		.divisor  (big),
		.quotient (qy),
		.done     (div_done_y)
	);

	// A single point box leaves every shifted coordinate at zero.
	assign sx     = degen ? '0 : qx;
	assign sy     = degen ? '0 : qy;
	assign rot_in = (state_q == pns_pkg::ST_SC_DIV) && div_done && div_done_y;

	pns_rotate #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (rot_in),
		.sx      (sx),
		.sy      (sy),
		.turns   (turns_q),
		.cos_v   (cos_q),
		.sin_v   (sin_q),
		.out_vld (rot_out),
		.rx      (rx),
		.ry      (ry)
	);

	assign ex = ram_rdata.x - WW'(rminx_q);
	assign ey = ram_rdata.y - WW'(rminy_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pns_pkg::ST_LOAD:     if (in_xfer && final_vertex) state_d = pns_pkg::ST_SC_RD;
			pns_pkg::ST_SC_RD:    state_d = pns_pkg::ST_SC_MUL;
			pns_pkg::ST_SC_MUL:   state_d = pns_pkg::ST_SC_DIVGO;
			pns_pkg::ST_SC_DIVGO: state_d = pns_pkg::ST_SC_DIV;
			pns_pkg::ST_SC_DIV:   if (div_done && div_done_y) state_d = pns_pkg::ST_SC_ROT;
			pns_pkg::ST_SC_ROT: begin
				if (rot_out) begin
					state_d = last_idx ? pns_pkg::ST_OUT_RD : pns_pkg::ST_SC_RD;
				end
			end
			pns_pkg::ST_OUT_RD:   state_d = pns_pkg::ST_OUT_LD;
			pns_pkg::ST_OUT_LD:   state_d = pns_pkg::ST_OUT_WAIT;
			pns_pkg::ST_OUT_WAIT: begin
				if (out_ready) begin
					state_d = last_idx ? pns_pkg::ST_LOAD : pns_pkg::ST_OUT_RD;
				end
			end
			default: state_d = pns_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pns_pkg::ST_LOAD;
			cnt_q     <= '0;
			idx_q     <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
			minx_q    <= '0;
			miny_q    <= '0;
			maxx_q    <= '0;
			maxy_q    <= '0;
			rminx_q   <= '0;
			rminy_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pns_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (!store_ok) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == '0 || vertex_x < minx_q) minx_q <= vertex_x;
							if (cnt_q == '0 || vertex_x > maxx_q) maxx_q <= vertex_x;
							if (cnt_q == '0 || vertex_y < miny_q) miny_q <= vertex_y;
							if (cnt_q == '0 || vertex_y > maxy_q) maxy_q <= vertex_y;
						end
						idx_q <= '0;
					end
				end
				pns_pkg::ST_SC_ROT: begin
					if (rot_out) begin
						if (idx_q == '0 || rx < rminx_q) rminx_q <= rx;
						if (idx_q == '0 || ry < rminy_q) rminy_q <= ry;
						idx_q <= last_idx ? '0 : idx_q + 1'b1;
					end
				end
				pns_pkg::ST_OUT_LD: out_valid <= 1'b1;
				pns_pkg::ST_OUT_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (last_idx) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == pns_pkg::ST_SC_MUL) begin
			prodx_q <= pns_pkg::PROD_W'(dx * target_q);
			prody_q <= pns_pkg::PROD_W'(dy * target_q);
		end
		if (state_q == pns_pkg::ST_OUT_LD) begin
			out_x      <= (ex > WW'(16'hFFFF)) ? 16'hFFFF : ex[CW-1:0];
			out_y      <= (ey > WW'(16'hFFFF)) ? 16'hFFFF : ey[CW-1:0];
			out_last   <= last_idx;
			degenerate <= degen;
			overflowed <= ovf_q;
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_polygon_normalize_scale_rotate.sv -----
// Self-checking testbench for polygon_normalize_scale_rotate, with directed and random polygons.
`timescale 1ns / 1ps
module tb_polygon_normalize_scale_rotate;

	localparam int NPTS       = 64;
	localparam int FRAC       = 14;
	localparam int DRAIN_CYC  = 40;
	localparam int RAND_ITEMS = 200;

	// Indexes past the register list; writes to them are ignored.
	localparam logic [pns_pkg::CFG_IDX_W-1:0] REG_NONE_FIRST = 3'd4;
	localparam logic [pns_pkg::CFG_IDX_W-1:0] REG_NONE_LAST  = 3'd7;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		bit last;
		bit degen;
		bit ovf;
	} vtx_out_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit fin;
		bit typed;
		logic [15:0] ex;
		logic [15:0] ey;
		bit edeg;
		bit eovf;
	} vtx_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [pns_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pns_pkg::TRIG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [pns_pkg::COORD_W-1:0] vertex_x;
	logic signed [pns_pkg::COORD_W-1:0] vertex_y;
	logic final_vertex;
	logic out_valid;
	logic out_ready;
	logic [pns_pkg::COORD_W-1:0] out_x;
	logic [pns_pkg::COORD_W-1:0] out_y;
	logic out_last;
	logic degenerate;
	logic overflowed;

	polygon_normalize_scale_rotate dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .final_vertex(final_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_last(out_last),
		.degenerate(degenerate), .overflowed(overflowed)
	);

	// Shadow copy of the block state and registers.
	int unsigned m_tsize;
	int unsigned m_qturns;
	int m_cos;
	int m_sin;
	int m_sx[NPTS];
	int m_sy[NPTS];
	int unsigned m_count;
	bit m_ovf;
	int bminx, bminy, bmaxx, bmaxy;

	vtx_out_t pending_vertices[$];
	vtx_out_t typed_vertices[$];
	vtx_row_t cur_row;
	int unsigned in_transfers;
	int unsigned out_transfers;
	int unsigned polygons_done;
	int unsigned mismatches;
	int unsigned in_idle_pct;
	int unsigned out_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("polygon_normalize_scale_rotate regression: fail");
		$finish;
	end

	function automatic void find_box();
		bminx = m_sx[0]; bmaxx = m_sx[0];
		bminy = m_sy[0]; bmaxy = m_sy[0];
		for (int i = 1; i < m_count; i++) begin
			if (m_sx[i] < bminx) bminx = m_sx[i];
			if (m_sx[i] > bmaxx) bmaxx = m_sx[i];
			if (m_sy[i] < bminy) bminy = m_sy[i];
			if (m_sy[i] > bmaxy) bmaxy = m_sy[i];
		end
	endfunction

	function automatic void shift_to_origin();
		find_box();
		for (int i = 0; i < m_count; i++) begin
			m_sx[i] -= bminx;
			m_sy[i] -= bminy;
		end
		find_box();
	endfunction

	function automatic longint trunc_frac(longint v);
		if (v < 0) return -((-v) >> FRAC);
		return v >> FRAC;
	endfunction

	// Advances the shadow state by one accepted vertex and queues the polygon on the final one.
	function automatic void transform_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
			bit fin, bit typed);
		int unsigned w, h, big, ux, uy;
		int x, y, t;
		bit degen;
		vtx_out_t o;
		degen = 1'b0;
		if (m_count < NPTS) begin
			m_sx[m_count] = int'(vx);
			m_sy[m_count] = int'(vy);
			m_count++;
		end else begin
			m_ovf = 1'b1;
		end
		if (!fin) return;
		shift_to_origin();
		w = bmaxx - bminx;
		h = bmaxy - bminy;
		big = (w > h) ? w : h;
		if (big == 0) begin
			degen = 1'b1;
		end else begin
			for (int i = 0; i < m_count; i++) begin
				ux = m_sx[i];
				uy = m_sy[i];
				m_sx[i] = int'((ux * m_tsize) / big);
				m_sy[i] = int'((uy * m_tsize) / big);
			end
		end
		for (int i = 0; i < m_count; i++) begin
			x = m_sx[i];
			y = m_sy[i];
			for (int q = 0; q < m_qturns; q++) begin
				t = x;
				x = -y;
				y = t;
			end
			m_sx[i] = int'(trunc_frac(longint'(x) * m_cos - longint'(y) * m_sin));
			m_sy[i] = int'(trunc_frac(longint'(x) * m_sin + longint'(y) * m_cos));
		end
		shift_to_origin();
		for (int i = 0; i < m_count; i++) begin
			ux = m_sx[i];
			uy = m_sy[i];
			o.x = (ux > 32'hFFFF) ? 16'hFFFF : ux[15:0];
			o.y = (uy > 32'hFFFF) ? 16'hFFFF : uy[15:0];
			o.last = (i + 1 == m_count);
			o.degen = degen;
			o.ovf = m_ovf;
			if (!typed) pending_vertices.push_back(o);
		end
		if (typed) begin
			while (typed_vertices.size() > 0) pending_vertices.push_back(typed_vertices.pop_front());
		end
		m_count = 0;
		m_ovf = 1'b0;
		polygons_done++;
	endfunction

	// Transfers are observed with pre-edge values at the rising edge.
	always @(posedge clk) begin
		vtx_out_t e;
		if (arst_n && in_valid && in_ready) begin
			if (cur_row.typed) begin
				e.x = cur_row.ex; e.y = cur_row.ey; e.last = cur_row.fin;
				e.degen = cur_row.edeg; e.ovf = cur_row.eovf;
				typed_vertices.push_back(e);
			end
			transform_vertex(vertex_x, vertex_y, final_vertex, cur_row.typed);
			in_transfers++;
		end
		if (arst_n && out_valid && out_ready) begin
			out_transfers++;
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output vertex x=%0d y=%0d", out_x, out_y);
			end else begin
				e = pending_vertices.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_last !== e.last ||
						degenerate !== e.degen || overflowed !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got x=%0d y=%0d last=%b deg=%b ovf=%b, exp x=%0d y=%0d last=%b deg=%b ovf=%b",
							out_x, out_y, out_last, degenerate, overflowed,
							e.x, e.y, e.last, e.degen, e.ovf);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= out_stall_pct);
	end

	task automatic write_reg(logic [pns_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			pns_pkg::REG_TARGET_SIZE:   m_tsize = 32'(val[11:0]);
			pns_pkg::REG_QUARTER_TURNS: m_qturns = 32'(val[1:0]);
			pns_pkg::REG_RESIDUAL_COS:  m_cos = int'($signed(val));
			pns_pkg::REG_RESIDUAL_SIN:  m_sin = int'($signed(val));
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_vertex(vtx_row_t r);
		int unsigned seen;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cur_row = r;
		vertex_x = r.x;
		vertex_y = r.y;
		final_vertex = r.fin;
		in_valid = 1'b1;
		seen = in_transfers;
		do @(negedge clk); while (in_transfers == seen);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_vertices.size() > 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic send_random_polygon(int unsigned npts);
		vtx_row_t r;
		int cx, cy, span;
		r.typed = 1'b0;
		cx = $urandom_range(65535) - 32768;
		cy = $urandom_range(65535) - 32768;
		span = 1 << $urandom_range(16);
		for (int i = 0; i < npts; i++) begin
			if (span >= 65536 || $urandom_range(7) == 0) begin
				r.x = 16'($urandom());
				r.y = 16'($urandom());
			end else begin
				r.x = 16'(cx + int'($urandom_range(span)) - span / 2);
				r.y = 16'(cy + int'($urandom_range(span)) - span / 2);
			end
			r.fin = (i == npts - 1);
			send_vertex(r);
		end
	endtask

	vtx_row_t dir_rows[$];

	function automatic vtx_row_t mk(int x, int y, int fin, int typed, int ex, int ey,
			int edeg);
		vtx_row_t r;
		r.x = 16'(x); r.y = 16'(y); r.fin = (fin != 0); r.typed = (typed != 0);
		r.ex = 16'(ex); r.ey = 16'(ey); r.edeg = (edeg != 0); r.eovf = 1'b0;
		return r;
	endfunction

	initial begin
		int unsigned rand_items, phase, n;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		final_vertex = 1'b0;
		cur_row = mk(0, 0, 0, 0, 0, 0, 0);
		in_transfers = 0; out_transfers = 0; polygons_done = 0; mismatches = 0;
		in_idle_pct = 0; out_stall_pct = 0;
		m_tsize = 256; m_qturns = 0; m_cos = 16384; m_sin = 0;
		m_count = 0; m_ovf = 1'b0;
		bminx = 0; bminy = 0; bmaxx = 0; bmaxy = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed polygons under the reset configuration; simple ones are typed in.
		dir_rows.push_back(mk(100, -5, 1, 1, 0, 0, 1));                 // single point
		dir_rows.push_back(mk(0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(mk(10, 0, 1, 1, 256, 0, 0));
		dir_rows.push_back(mk(-32768, -32768, 0, 1, 0, 0, 0));          // full range
		dir_rows.push_back(mk(32767, 32767, 1, 1, 256, 256, 0));
		dir_rows.push_back(mk(-32768, 32767, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(32767, -32768, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(5, 7, 1, 0, 0, 0, 0));
		dir_rows.push_back(mk(3, 3, 0, 1, 0, 0, 1));                    // repeated point
		dir_rows.push_back(mk(3, 3, 1, 1, 0, 0, 1));
		dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(0, 20, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(-7, 13, 1, 0, 0, 0, 0));
		foreach (dir_rows[i]) send_vertex(dir_rows[i]);
		wait_idle();

		// Extreme registers: largest size, three turns, raw trig values, ignored indexes.
		write_reg(pns_pkg::REG_TARGET_SIZE, 16'hFFFF);
		write_reg(pns_pkg::REG_QUARTER_TURNS, 16'd3);
		write_reg(pns_pkg::REG_RESIDUAL_COS, 16'h8000);
		write_reg(pns_pkg::REG_RESIDUAL_SIN, 16'h7FFF);
		write_reg(REG_NONE_FIRST, 16'h1234);
		write_reg(REG_NONE_LAST, 16'hFFFF);
		foreach (dir_rows[i]) begin
			dir_rows[i].typed = 1'b0;
			send_vertex(dir_rows[i]);
		end
		send_random_polygon(NPTS + 3);   // store full, extras and final dropped
		send_random_polygon(NPTS);
		wait_idle();
		write_reg(pns_pkg::REG_TARGET_SIZE, 16'd0);  // scales everything to zero
		write_reg(pns_pkg::REG_QUARTER_TURNS, 16'd2);
		send_random_polygon(4);
		wait_idle();
		write_reg(pns_pkg::REG_TARGET_SIZE, 16'd1);
		write_reg(pns_pkg::REG_RESIDUAL_COS, 16'hC000);
		write_reg(pns_pkg::REG_RESIDUAL_SIN, 16'h4000);
		send_random_polygon(5);
		wait_idle();

		// Random phases, each with its own registers and flow-control pattern.
		rand_items = 0;
		phase = 0;
		while (rand_items < RAND_ITEMS) begin
			case (phase % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 78; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 78; end
				default: begin in_idle_pct = 18; out_stall_pct = 18; end
			endcase
			write_reg(pns_pkg::REG_TARGET_SIZE,
				(phase % 5 == 0) ? (16'hF000 | 16'd4095) : 16'($urandom()));
			write_reg(pns_pkg::REG_QUARTER_TURNS, 16'($urandom_range(3)));
			write_reg(pns_pkg::REG_RESIDUAL_COS, 16'($urandom_range(32768) - 16384));
			write_reg(pns_pkg::REG_RESIDUAL_SIN, 16'($urandom_range(32768) - 16384));
			for (int p = 0; p < 3 && rand_items < RAND_ITEMS; p++) begin
				case ($urandom_range(19))
					0: n = $urandom_range(NPTS + 4, NPTS - 2);
					1: n = 1;
					default: n = $urandom_range(12, 2);
				endcase
				send_random_polygon(n);
				rand_items += n;
			end
			wait_idle();
			phase++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_vertices.size() > 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
		$display("covered %0d polygons, %0d input and %0d output transfers over %0d phases",
			polygons_done, in_transfers, out_transfers, phase);
		$display("register extremes, overflowed stores, single-point boxes and stalls exercised");
		if (mismatches == 0 && pending_vertices.size() == 0) begin
			$display("polygon_normalize_scale_rotate regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_vertices.size());
			$display("polygon_normalize_scale_rotate regression: fail");
		end
		$finish;
	end

endmodule
